// File: hw/rtl/pqem_pkg.sv
`default_nettype none

package pqem_pkg;

   // Default queue depth
   localparam int PQEM_CAPACITY = 16;

   // Field widths
   localparam int KIND_W    = 2;
   localparam int TAG_W     = 16;
   localparam int PRI_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int ELAPSED_W = 32;
   localparam int COUNT_W   = 5;
   localparam int SVC_W     = 8;

   // Service time after reset
   localparam logic [SVC_W-1:0] SVC_RESET = 8'd5;

   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [TAG_W-1:0]     tag_type;
   typedef logic [PRI_W-1:0]     pri_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [ELAPSED_W-1:0] elapsed_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [SVC_W-1:0]     svc_type;

   // Request kinds
   localparam kind_type KIND_ADD     = 2'd0;
   localparam kind_type KIND_EXTRACT = 2'd1;
   localparam kind_type KIND_CLEAR   = 2'd2;

   // Response status codes
   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_DROPPED = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;

   // One queue entry as held in the store
   typedef struct packed {
      tag_type tag;
      pri_type pri;
   } entry_type;

endpackage

`default_nettype wire

// File: hw/rtl/pqem_store.sv
`default_nettype none

module pqem_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire pqem_pkg::entry_type  wr_data,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output pqem_pkg::entry_type       rd_data
);
   import pqem_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/priority_queue_extract_max.sv
// Add, clear and unused kinds: the sequencer goes from S_IDLE to S_EMIT, which loads the
// response register. Extract: S_SCAN reads every held entry and picks the winner, S_SHIFT
// moves each entry above it down one place, then S_EMIT. The entry store has one read port.
// Requests are taken only in S_IDLE, also while the last response still waits for rsp_ready.
// Synchronous active-high reset empties the queue, zeroes elapsed time, sets service time 5.
`default_nettype none

module priority_queue_extract_max #(
   parameter int CAPACITY = pqem_pkg::PQEM_CAPACITY
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire pqem_pkg::kind_type      req_kind,
   input  wire pqem_pkg::tag_type       req_tag_in,
   input  wire pqem_pkg::pri_type       req_priority_in,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output pqem_pkg::status_type         rsp_status,
   output pqem_pkg::tag_type            rsp_tag_out,
   output pqem_pkg::pri_type            rsp_priority_out,
   output pqem_pkg::elapsed_type        rsp_elapsed,
   output pqem_pkg::count_type          rsp_count,
   output logic                         rsp_empty_res,
   output logic                         rsp_full_res,
   // configuration
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire pqem_pkg::svc_type       csr_service_time
);
   import pqem_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   pri_type           best_pri_ff, best_pri_in;
   tag_type           best_tag_ff, best_tag_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   elapsed_type       elapsed_ff, elapsed_in;
   svc_type           svc_ff, svc_in;
   status_type        res_status_ff, res_status_in;
   tag_type           res_tag_ff, res_tag_in;
   pri_type           res_pri_ff, res_pri_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   tag_type           rsp_tag_ff, rsp_tag_in;
   pri_type           rsp_pri_ff, rsp_pri_in;
   elapsed_type       rsp_elapsed_ff, rsp_elapsed_in;
   count_type         rsp_count_ff, rsp_count_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_full_ff, rsp_full_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;

   logic              req_take;
   logic              rsp_load;
   logic              full;
   logic [ADDR_W-1:0] last;
   logic              take_new;
   pri_type           nb_pri;
   tag_type           nb_tag;
   logic [ADDR_W-1:0] nb_pos;
   logic [COUNT_W+OCC_W-1:0] count_ext;

   pqem_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign full      = (occ_ff == OCC_W'(CAPACITY));
   assign last      = ADDR_W'(occ_ff - 1'b1);

   // Compare unit: running maximum, earliest entry wins a tie
   assign take_new = (idx_ff == '0) || (rd_data.pri > best_pri_ff);
   assign nb_pri   = take_new ? rd_data.pri : best_pri_ff;
   assign nb_tag   = take_new ? rd_data.tag : best_tag_ff;
   assign nb_pos   = take_new ? idx_ff : pos_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      best_pri_in   = best_pri_ff;
      best_tag_in   = best_tag_ff;
      occ_in        = occ_ff;
      elapsed_in    = elapsed_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_pri_in    = res_pri_ff;
      wr_en         = 1'b0;
      wr_addr       = occ_ff[ADDR_W-1:0];
      wr_data       = '{tag: req_tag_in, pri: req_priority_in};

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_status_in = ST_DONE;
               res_tag_in    = '0;
               res_pri_in    = '0;
               state_in      = S_EMIT;
               case (req_kind)
                  KIND_ADD: begin
                     if (full) begin
                        res_status_in = ST_DROPPED;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = OCC_W'(occ_ff + 1'b1);
                     end
                  end
                  KIND_EXTRACT: begin
                     if (occ_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  KIND_CLEAR: begin
                     occ_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // rd_data holds the entry at idx_ff
         S_SCAN: begin
            best_pri_in = nb_pri;
            best_tag_in = nb_tag;
            pos_in      = nb_pos;
            if (idx_ff == last) begin
               if (nb_pos == last) begin
                  occ_in        = OCC_W'(occ_ff - 1'b1);
                  elapsed_in    = elapsed_ff + ELAPSED_W'(svc_ff);
                  res_status_in = ST_DONE;
                  res_tag_in    = nb_tag;
                  res_pri_in    = nb_pri;
                  state_in      = S_EMIT;
               end else begin
                  idx_in   = ADDR_W'(nb_pos + 1'b1);
                  state_in = S_SHIFT;
               end
            end else begin
               idx_in = ADDR_W'(idx_ff + 1'b1);
            end
         end

         // Move the entry at idx_ff down one place
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(idx_ff - 1'b1);
            wr_data = rd_data;
            if (idx_ff == last) begin
               occ_in        = OCC_W'(occ_ff - 1'b1);
               elapsed_in    = elapsed_ff + ELAPSED_W'(svc_ff);
               res_status_in = ST_DONE;
               res_tag_in    = best_tag_ff;
               res_pri_in    = best_pri_ff;
               state_in      = S_EMIT;
            end else begin
               idx_in = ADDR_W'(idx_ff + 1'b1);
            end
         end

         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   assign rsp_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign count_ext = {{COUNT_W{1'b0}}, occ_ff};

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_pri_in     = rsp_pri_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_full_in    = rsp_full_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_tag_in     = res_tag_ff;
         rsp_pri_in     = res_pri_ff;
         rsp_elapsed_in = elapsed_ff;
         rsp_count_in   = count_ext[COUNT_W-1:0];
         rsp_empty_in   = (occ_ff == '0);
         rsp_full_in    = full;
      end
   end

   // Configuration write
   assign svc_in = (csr_valid && csr_ready) ? csr_service_time : svc_ff;

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      best_pri_ff    <= best_pri_in;
      best_tag_ff    <= best_tag_in;
      res_status_ff  <= res_status_in;
      res_tag_ff     <= res_tag_in;
      res_pri_ff     <= res_pri_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_pri_ff     <= rsp_pri_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         elapsed_ff   <= '0;
         svc_ff       <= SVC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         elapsed_ff   <= elapsed_in;
         svc_ff       <= svc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_tag_out      = rsp_tag_ff;
   assign rsp_priority_out = rsp_pri_ff;
   assign rsp_elapsed      = rsp_elapsed_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_full_res     = rsp_full_ff;

endmodule

`default_nettype wire
